FILE: design/blz_pkg.sv
// shared types, constants and helpers for the backward lz decompressor
// no dependencies; used by blz_outreg, blz_ctrl and the top level
package blz_pkg;

  localparam int HISTORY_DEPTH_DEF = 8192;
  localparam int LENGTH_BITS_DEF   = 24;
  localparam int POS_W             = 24;

  localparam logic [3:0] FLAGS_PER_CTRL = 4'd8;
  localparam logic [4:0] MIN_MATCH_LEN  = 5'd3;
  localparam logic [12:0] MIN_MATCH_DIST = 13'd3;

  typedef enum logic [2:0] {
    PH_CTRL,
    PH_LIT,
    PH_THI,
    PH_TLO,
    PH_MATCH,
    PH_HALT
  } blz_phase_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EXHAUSTED,
    ST_BAD_REF
  } blz_status_e;

  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    blz_status_e      status;
    logic             last;
  } blz_item_t;

  typedef struct packed {
    blz_phase_e  phase;
    logic [7:0]  flags;
    logic [3:0]  left;
  } blz_flag_t;

  // advance to the next flag after a literal or a finished match
  function automatic blz_flag_t next_flag(logic [7:0] flags, logic [3:0] left, logic done);
    blz_flag_t r;
    r.flags = {flags[6:0], 1'b0};
    r.left  = (left != 4'd0) ? left - 4'd1 : left;
    if (done) begin
      r.phase = PH_HALT;
    end else if (r.left == 4'd0) begin
      r.phase = PH_CTRL;
    end else if (r.flags[7]) begin
      r.phase = PH_THI;
    end else begin
      r.phase = PH_LIT;
    end
    return r;
  endfunction

endpackage

FILE: design/blz_hist_ram.sv
// history store: single-port-write, single-port-read synchronous ram
// read data registered; no dependencies
module blz_hist_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/blz_outreg.sv
// output word register between the decoder and the result stream
// depends on blz_pkg for the result word type
module blz_outreg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  blz_pkg::blz_item_t item_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              ready_i,
  output blz_pkg::blz_item_t item_o
);

  logic               valid_q, valid_d;
  blz_pkg::blz_item_t item_q;

  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: design/blz_ctrl.sv
// decode sequencer: control bytes, literals, tokens and match copy loop
// depends on blz_pkg; drives blz_hist_ram and blz_outreg
module blz_ctrl #(
  parameter int HISTORY_DEPTH = blz_pkg::HISTORY_DEPTH_DEF,
  parameter int LENGTH_BITS   = blz_pkg::LENGTH_BITS_DEF,
  parameter int AW            = $clog2(HISTORY_DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   restart_i,
  input  logic [LENGTH_BITS-1:0] olen_new_i,
  input  logic [LENGTH_BITS-1:0] olen_i,
  input  logic [LENGTH_BITS-1:0] ilen_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [7:0]             in_byte_i,
  input  logic                   out_free_i,
  output logic                   out_load_o,
  output blz_pkg::blz_item_t     out_item_o,
  output logic                   ram_re_o,
  output logic [AW-1:0]          ram_raddr_o,
  input  logic [7:0]             ram_rdata_i,
  output logic                   ram_we_o,
  output logic [AW-1:0]          ram_waddr_o,
  output logic [7:0]             ram_wdata_o
);

  localparam int PW = (LENGTH_BITS > blz_pkg::POS_W) ? LENGTH_BITS : blz_pkg::POS_W;
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(HISTORY_DEPTH);

  blz_pkg::blz_phase_e    phase_q, phase_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [LENGTH_BITS-1:0] cons_q, cons_d;
  logic [7:0]             flag_q, flag_d;
  logic [3:0]             fleft_q, fleft_d;
  logic [7:0]             tokhi_q, tokhi_d;
  logic [AW-1:0]          wslot_q, wslot_d;
  logic [AW-1:0]          rslot_q, rslot_d;
  logic [4:0]             mlen_q, mlen_d;
  logic                   pend_q, pend_d;

  logic                   acc, drop, exhausted, ref_err, emit, last_out;
  logic [LENGTH_BITS-1:0] rem_m1;
  logic [PW-1:0]          pos_ext;
  logic [AW-1:0]          wslot_m1, rslot_m1, rslot_start;
  logic [AW:0]            rsum;
  logic [4:0]             len_raw, len_c;
  logic [12:0]            match_dist;
  logic [LENGTH_BITS:0]   ref_top;
  blz_pkg::blz_flag_t     nf;

  // shared datapath
  assign rem_m1   = rem_q - LENGTH_BITS'(1);
  assign pos_ext  = PW'(rem_m1);
  assign last_out = (rem_q == LENGTH_BITS'(1));
  assign wslot_m1 = (wslot_q == '0) ? LAST_SLOT : wslot_q - AW'(1);
  assign rslot_m1 = (rslot_q == '0) ? LAST_SLOT : rslot_q - AW'(1);

  assign in_ready_o = (phase_q != blz_pkg::PH_MATCH) && out_free_i;
  assign acc        = in_valid_i && in_ready_o;
  assign drop       = (phase_q == blz_pkg::PH_HALT) || (rem_q == '0);
  assign exhausted  = ({1'b0, cons_q} >= {1'b0, ilen_i}) ||
                      ((phase_q == blz_pkg::PH_THI) &&
                       ({1'b0, cons_q} + (LENGTH_BITS + 1)'(1) >= {1'b0, ilen_i}));

  // token fields, clip and reference range check
  assign len_raw    = {1'b0, tokhi_q[7:4]} + blz_pkg::MIN_MATCH_LEN;
  assign match_dist = {1'b0, tokhi_q[3:0], in_byte_i} + blz_pkg::MIN_MATCH_DIST;
  assign len_c      = (LENGTH_BITS'(len_raw) > rem_q) ? rem_q[4:0] : len_raw;
  assign ref_top    = {1'b0, rem_q} + (LENGTH_BITS + 1)'(match_dist);
  assign ref_err    = ref_top > {1'b0, olen_i};

  // slot of the highest source byte, wrapped once
  assign rsum        = {1'b0, wslot_q} + (AW + 1)'(match_dist) - (AW + 1)'(1);
  assign rslot_start = (rsum >= DEPTH_X) ? AW'(rsum - DEPTH_X) : rsum[AW-1:0];

  assign emit = (phase_q == blz_pkg::PH_MATCH) && pend_q && out_free_i;
  assign nf   = blz_pkg::next_flag(flag_q, fleft_q, last_out);

  // outputs: history port and result word
  always_comb begin
    out_load_o  = 1'b0;
    out_item_o  = '0;
    ram_re_o    = 1'b0;
    ram_raddr_o = rslot_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = wslot_m1;
    ram_wdata_o = in_byte_i;
    unique case (phase_q)
      blz_pkg::PH_MATCH: begin
        ram_re_o = (mlen_q != 5'd0) && (!pend_q || out_free_i);
        if (emit) begin
          out_load_o      = 1'b1;
          ram_we_o        = 1'b1;
          ram_wdata_o     = ram_rdata_i;
          out_item_o.data = ram_rdata_i;
          out_item_o.pos  = pos_ext[blz_pkg::POS_W-1:0];
          out_item_o.last = last_out;
        end
      end
      blz_pkg::PH_CTRL, blz_pkg::PH_LIT, blz_pkg::PH_THI, blz_pkg::PH_TLO,
      blz_pkg::PH_HALT: begin
        if (acc && !drop) begin
          if (exhausted) begin
            out_load_o        = 1'b1;
            out_item_o.status = blz_pkg::ST_EXHAUSTED;
            out_item_o.last   = 1'b1;
          end else if (phase_q == blz_pkg::PH_LIT) begin
            out_load_o      = 1'b1;
            ram_we_o        = 1'b1;
            out_item_o.data = in_byte_i;
            out_item_o.pos  = pos_ext[blz_pkg::POS_W-1:0];
            out_item_o.last = last_out;
          end else if ((phase_q == blz_pkg::PH_TLO) && ref_err) begin
            out_load_o        = 1'b1;
            out_item_o.status = blz_pkg::ST_BAD_REF;
            out_item_o.last   = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    cons_d  = cons_q;
    flag_d  = flag_q;
    fleft_d = fleft_q;
    tokhi_d = tokhi_q;
    wslot_d = wslot_q;
    rslot_d = rslot_q;
    mlen_d  = mlen_q;
    pend_d  = pend_q;
    if (restart_i) begin
      phase_d = blz_pkg::PH_CTRL;
      rem_d   = olen_new_i;
      cons_d  = '0;
      flag_d  = '0;
      fleft_d = '0;
      tokhi_d = '0;
      wslot_d = '0;
      mlen_d  = '0;
      pend_d  = 1'b0;
    end else if (phase_q == blz_pkg::PH_MATCH) begin
      if (ram_re_o) begin
        rslot_d = rslot_m1;
        mlen_d  = mlen_q - 5'd1;
        pend_d  = 1'b1;
      end else if (emit) begin
        pend_d = 1'b0;
      end
      if (emit) begin
        rem_d   = rem_m1;
        wslot_d = wslot_m1;
        if (mlen_q == 5'd0) begin
          phase_d = nf.phase;
          flag_d  = nf.flags;
          fleft_d = nf.left;
        end
      end
    end else if (acc && !drop) begin
      if (exhausted) begin
        phase_d = blz_pkg::PH_HALT;
      end else begin
        cons_d = cons_q + LENGTH_BITS'(1);
        unique case (phase_q)
          blz_pkg::PH_CTRL: begin
            flag_d  = in_byte_i;
            fleft_d = blz_pkg::FLAGS_PER_CTRL;
            phase_d = in_byte_i[7] ? blz_pkg::PH_THI : blz_pkg::PH_LIT;
          end
          blz_pkg::PH_LIT: begin
            rem_d   = rem_m1;
            wslot_d = wslot_m1;
            phase_d = nf.phase;
            flag_d  = nf.flags;
            fleft_d = nf.left;
          end
          blz_pkg::PH_THI: begin
            tokhi_d = in_byte_i;
            phase_d = blz_pkg::PH_TLO;
          end
          blz_pkg::PH_TLO: begin
            if (ref_err) begin
              phase_d = blz_pkg::PH_HALT;
            end else begin
              phase_d = blz_pkg::PH_MATCH;
              mlen_d  = len_c;
              rslot_d = rslot_start;
              pend_d  = 1'b0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= blz_pkg::PH_CTRL;
      rem_q   <= '0;
      cons_q  <= '0;
      flag_q  <= '0;
      fleft_q <= '0;
      tokhi_q <= '0;
      wslot_q <= '0;
      rslot_q <= '0;
      mlen_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      cons_q  <= cons_d;
      flag_q  <= flag_d;
      fleft_q <= fleft_d;
      tokhi_q <= tokhi_d;
      wslot_q <= wslot_d;
      rslot_q <= rslot_d;
      mlen_q  <= mlen_d;
      pend_q  <= pend_d;
    end
  end

`ifndef ASSERT_OFF
  // a history write always goes with a result word
  a_write_with_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> out_load_o)
    else $error("history write without result word");

  // pending read data only exists inside a match
  a_pend_in_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (phase_q == blz_pkg::PH_MATCH))
    else $error("read pending outside match");

  // error words carry zero data and position and close the run
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load_o && (out_item_o.status != blz_pkg::ST_OK)) |->
      (out_item_o.last && (out_item_o.data == 8'd0) && (out_item_o.pos == '0)))
    else $error("malformed error word");

  // a word loaded while data was pending lowers the count of bytes left
  a_emit_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !restart_i) |=> (rem_q == $past(rem_m1)))
    else $error("remaining count not decremented on match byte");
`endif

endmodule

FILE: design/backward_lz_decompressor_top.sv
// top level of the backward lz decompressor: register port, history ram,
// decode sequencer and output register; depends on blz_pkg and all blz_* modules
//
// usage
//   program output_length (addr 0) and input_length (addr 4) over the apb
//   port; every write restarts decoding at position output_length - 1
//   feed compressed bytes on s_axis from the highest stream address down,
//   one byte per word in tdata[7:0]
//   results leave on m_axis, one word per output byte in descending position:
//   tdata = {position, byte}, tuser = status, tlast marks position 0 or an error
//   a literal accepted on s_axis is registered in the output register and shows
//   on m_axis in the next cycle; control, literal and token bytes are accepted one
//   per cycle while the output register is free; after the low token byte, input
//   is held off while the match copy loop reads the history ram (registered read
//   data) and writes one byte per cycle back while the output register is free
//   a stall on m_axis freezes the copy loop and input; the output register
//   holds one finished word, and the next one loads as it leaves
//   after an error the block swallows input without results until restarted
//   reset clears control state and registers; the history ram is not cleared
//   and needs no clearing pass
module backward_lz_decompressor_top #(
  parameter int HISTORY_DEPTH = blz_pkg::HISTORY_DEPTH_DEF,
  parameter int LENGTH_BITS   = blz_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // compressed byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // decompressed byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [31:8] out_position
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast    // final_flag
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  // config registers
  logic [LENGTH_BITS-1:0] olen_q, olen_d;
  logic [LENGTH_BITS-1:0] ilen_q, ilen_d;
  logic                   cfg_wr;

  // internal links
  logic                   out_free, out_load;
  blz_pkg::blz_item_t     out_item, m_item;
  logic                   ram_re, ram_we;
  logic [AW-1:0]          ram_raddr, ram_waddr;
  logic [7:0]             ram_rdata, ram_wdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // address bit 2 picks the register
  always_comb begin
    olen_d = olen_q;
    ilen_d = ilen_q;
    if (cfg_wr) begin
      if (paddr[2]) begin
        ilen_d = pwdata[LENGTH_BITS-1:0];
      end else begin
        olen_d = pwdata[LENGTH_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      olen_q <= '0;
      ilen_q <= '0;
    end else begin
      olen_q <= olen_d;
      ilen_q <= ilen_d;
    end
  end

  assign prdata = paddr[2] ? 32'(ilen_q) : 32'(olen_q);

  blz_hist_ram #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (AW)
  ) u_hist (
    .clk_i   (clk_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata)
  );

  // restart takes the freshly written output length
  blz_ctrl #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .LENGTH_BITS   (LENGTH_BITS),
    .AW            (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_wr),
    .olen_new_i  (olen_d),
    .olen_i      (olen_q),
    .ilen_i      (ilen_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .out_item_o  (out_item),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  blz_outreg u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (out_load),
    .item_i  (out_item),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .item_o  (m_item)
  );

  // word packing: byte low, position above
  assign m_axis_tdata = {m_item.pos, m_item.data};
  assign m_axis_tuser = m_item.status;
  assign m_axis_tlast = m_item.last;

endmodule

FILE: sim/backward_lz_decompressor_top_test.sv
// self-checking bench for backward_lz_decompressor_top: programs the lengths over apb,
// streams compressed bytes in and checks every decoded word against a built-in decoder
// depends on blz_pkg and the design sources only
`timescale 1ns / 1ps

module backward_lz_decompressor_top_test;

  localparam int HIST_DEPTH    = blz_pkg::HISTORY_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 150;
  localparam int SETTLE_CYCLES = 40;   // room for a token still in flight with no word owed
  localparam int TAIL_CYCLES   = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;

  // register indexes; byte address is 4 * index
  typedef enum int {
    REG_OUTPUT_LENGTH = 0,
    REG_INPUT_LENGTH  = 1
  } blz_reg_e;

  // --------------------------------------------------------------------------
  // decoder model and word checker
  // --------------------------------------------------------------------------
  class blz_decode_checker;
    bit   [7:0]  history [HIST_DEPTH];
    logic [23:0] out_len    = '0;
    logic [23:0] in_len     = '0;
    logic [23:0] remaining  = '0;
    logic [23:0] consumed   = '0;
    logic [7:0]  flag_bits  = '0;
    logic [7:0]  token_hi   = '0;
    logic [3:0]  flags_left = '0;
    blz_pkg::blz_phase_e phase = blz_pkg::PH_CTRL;
    blz_pkg::blz_item_t  decoded_words [$];
    int          errors     = 0;

    function void restart();
      remaining  = out_len;
      consumed   = '0;
      flag_bits  = '0;
      flags_left = '0;
      token_hi   = '0;
      phase      = blz_pkg::PH_CTRL;
    endfunction

    function void set_reg(blz_reg_e idx, logic [23:0] val);
      if (idx == REG_OUTPUT_LENGTH) begin
        out_len = val;
      end else begin
        in_len = val;
      end
      restart();
    endfunction

    function void pick_by_flag();
      phase = flag_bits[7] ? blz_pkg::PH_THI : blz_pkg::PH_LIT;
    endfunction

    function void advance_flag();
      flag_bits = {flag_bits[6:0], 1'b0};
      if (flags_left != 4'd0) flags_left--;
      if (remaining == '0) begin
        phase = blz_pkg::PH_HALT;
      end else if (flags_left == 4'd0) begin
        phase = blz_pkg::PH_CTRL;
      end else begin
        pick_by_flag();
      end
    endfunction

    function void add_word(logic [7:0] d, logic [23:0] p, blz_pkg::blz_status_e s,
                           logic l);
      blz_pkg::blz_item_t w;
      w.data   = d;
      w.pos    = p;
      w.status = s;
      w.last   = l;
      decoded_words = {decoded_words, w};
    endfunction

    // one accepted compressed byte; appends the words it produces
    function void decode_byte(logic [7:0] b);
      logic [23:0] avail;
      logic [23:0] pos;
      logic [23:0] base;
      logic [15:0] tok;
      logic [4:0]  len;
      logic [12:0] match_dist;
      logic [25:0] reach;
      logic [25:0] src;
      if (phase == blz_pkg::PH_HALT || remaining == '0) return;
      avail = (in_len > consumed) ? in_len - consumed : 24'd0;
      // out of input, a token needs both of its bytes inside the limit
      if (avail == '0 || (phase == blz_pkg::PH_THI && avail < 24'd2)) begin
        add_word(8'h00, 24'd0, blz_pkg::ST_EXHAUSTED, 1'b1);
        phase = blz_pkg::PH_HALT;
        return;
      end
      consumed++;
      case (phase)
        blz_pkg::PH_CTRL: begin
          flag_bits  = b;
          flags_left = 4'd8;
          pick_by_flag();
        end
        blz_pkg::PH_LIT: begin
          pos = remaining - 24'd1;
          history[pos % HIST_DEPTH] = b;
          add_word(b, pos, blz_pkg::ST_OK, pos == '0);
          remaining = pos;
          advance_flag();
        end
        blz_pkg::PH_THI: begin
          token_hi = b;
          phase    = blz_pkg::PH_TLO;
        end
        default: begin
          tok        = {token_hi, b};
          len        = {1'b0, tok[15:12]} + 5'd3;
          match_dist = {1'b0, tok[11:0]} + 13'd3;
          if (24'(len) > remaining) len = remaining[4:0];
          base  = remaining - 24'(len);
          reach = 26'(base) + 26'(len) - 26'd1 + 26'(match_dist);
          if (reach >= 26'(out_len)) begin
            add_word(8'h00, 24'd0, blz_pkg::ST_BAD_REF, 1'b1);
            phase = blz_pkg::PH_HALT;
            return;
          end
          for (int i = int'(len); i > 0; i--) begin
            pos = base + 24'(i - 1);
            src = 26'(pos) + 26'(match_dist);
            history[pos % HIST_DEPTH] = history[src % HIST_DEPTH];
            add_word(history[pos % HIST_DEPTH], pos, blz_pkg::ST_OK, pos == '0);
          end
          remaining = base;
          advance_flag();
        end
      endcase
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= 50) $display("mismatch: %s", what);
    endtask

    task check_word(logic [7:0] data, logic [23:0] pos, logic [1:0] st, logic last);
      blz_pkg::blz_item_t want;
      if (decoded_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word byte %02h pos %0d status %0d last %0b",
                                  data, pos, st, last));
        return;
      end
      want = decoded_words.pop_front();
      if (data !== want.data)
        report_mismatch($sformatf("pos %0d: byte %02h, want %02h", want.pos, data, want.data));
      if (pos !== want.pos)
        report_mismatch($sformatf("position %0d, want %0d", pos, want.pos));
      if (st !== want.status)
        report_mismatch($sformatf("pos %0d: status %0d, want %0d", want.pos, st, want.status));
      if (last !== want.last)
        report_mismatch($sformatf("pos %0d: last %0b, want %0b", want.pos, last, want.last));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [2:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] in_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;         // [7:0] out_byte, [31:8] out_position
  logic [1:0]  m_axis_tuser;         // [1:0] status
  logic        m_axis_tlast;         // final_flag

  // idle percentages per side, changed between regimes
  int send_idle_pct = 27;
  int recv_idle_pct = 61;
  // long receiver hold-off, counted down by the receiver process
  int rx_hold_left  = 0;
  int cycles        = 0;

  logic [7:0] comp_bytes [$];   // compressed stream of the current case
  blz_decode_checker dec = new;

  backward_lz_decompressor_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a missing word ends here
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // receiver: samples the word just before each edge takes effect, then picks
  // the next tready; a pending hold-off wins over the random idling
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready)
        dec.check_word(m_axis_tdata[7:0], m_axis_tdata[31:8], m_axis_tuser, m_axis_tlast);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // apb write: setup, access, then an idle step with psel low, so back-to-back
  // writes never drive psel twice in one step
  task automatic write_reg(input blz_reg_e idx, input logic [23:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(int'(idx) * 4);
    pwdata  <= {8'h00, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    dec.set_reg(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one compressed byte; tvalid stays up afterwards unless the next
  // call idles, so a steady stream never lowers and raises it in one step
  task automatic push_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    dec.decode_byte(b);
  endtask

  // program both lengths in random order, feed the stream, wait for every
  // owed word and give a token without words time to finish
  task automatic play_case(input logic [23:0] out_total, input logic [23:0] in_total);
    if ($urandom_range(1)) begin
      write_reg(REG_OUTPUT_LENGTH, out_total);
      write_reg(REG_INPUT_LENGTH, in_total);
    end else begin
      write_reg(REG_INPUT_LENGTH, in_total);
      write_reg(REG_OUTPUT_LENGTH, out_total);
    end
    foreach (comp_bytes[k]) push_byte(comp_bytes[k]);
    s_axis_tvalid <= 1'b0;
    while (dec.decoded_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // well-formed stream for total output bytes: distances only reach bytes
  // already produced; with fault_pct some tokens point past the written part
  function automatic void compose_stream(input int unsigned total, input int fault_pct);
    int unsigned done_cnt;
    int unsigned len;
    int unsigned match_dist;
    int unsigned maxd;
    logic [7:0]  ctrl;
    logic [7:0]  body [$];
    logic [15:0] tok;
    comp_bytes.delete();
    done_cnt = 0;
    while (done_cnt < total) begin
      ctrl = '0;
      body.delete();
      for (int k = 7; k >= 0; k--) begin
        if (done_cnt >= total) begin
          // flags after the last byte are never used
          ctrl[k] = 1'($urandom_range(1));
        end else if (done_cnt >= 3 && $urandom_range(99) < 45) begin
          ctrl[k] = 1'b1;
          len  = $urandom_range(18, 3);
          maxd = (done_cnt > 4098) ? 4098 : done_cnt;
          match_dist = $urandom_range(maxd, 3);
          if (done_cnt < 4098 && $urandom_range(99) < fault_pct)
            match_dist = $urandom_range(4098, done_cnt + 1);
          tok = {4'(len - 3), 12'(match_dist - 3)};
          body = {body, tok[15:8]};
          body = {body, tok[7:0]};
          done_cnt += len;
        end else begin
          body = {body, 8'($urandom_range(255))};
          done_cnt++;
        end
      end
      comp_bytes = {comp_bytes, ctrl};
      foreach (body[j]) comp_bytes = {comp_bytes, body[j]};
    end
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int          fed_items;
    int          body_len;
    int          sel;
    int          phase_no;
    int unsigned total;
    logic [23:0] in_total;
    fed_items = 0;
    phase_no  = 0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // nothing to produce: the byte is swallowed
    comp_bytes = '{8'h00};
    play_case(24'd0, 24'd0);
    // no input at all: first byte reports exhaustion
    comp_bytes = '{8'hFF};
    play_case(24'd3, 24'd0);
    // literals of both extremes, longest token clipped to the last two
    // bytes, then a trailing byte after position 0
    comp_bytes = '{8'h10, 8'h00, 8'hFF, 8'hA5, 8'hF0, 8'h00, 8'h5A};
    play_case(24'd5, 24'hFFFFFF);
    // farthest distance at the start reaches past the output, then halted
    comp_bytes = '{8'h80, 8'h0F, 8'hFF, 8'h77};
    play_case(24'd4, 24'd4);
    // token whose low byte lies past the input limit
    comp_bytes = '{8'h40, 8'h11, 8'hC3};
    play_case(24'd10, 24'd3);
    // top output position, then input runs out on a literal
    comp_bytes = '{8'h00, 8'h3C, 8'h00};
    play_case(24'hFFFFFF, 24'd2);

    while (fed_items < RANDOM_ITEMS) begin
      if (fed_items < RANDOM_ITEMS / 3) begin
        send_idle_pct = 27;
        recv_idle_pct = 61;
      end else if (fed_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 27;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      if (phase_no == 0) begin
        total = 150;
      end else if ($urandom_range(99) < 5) begin
        total = $urandom_range(400, 200);
      end else begin
        total = $urandom_range(60, 1);
      end
      compose_stream(total, ($urandom_range(9) == 0) ? 10 : 0);
      body_len = comp_bytes.size();

      // mostly the input size plus up to two bytes, sometimes short, sometimes unlimited
      sel = $urandom_range(9);
      if (sel == 0 && body_len > 1) begin
        in_total = 24'($urandom_range(body_len - 1, 0));
      end else if (sel == 1) begin
        in_total = 24'hFFFFFF;
      end else begin
        in_total = 24'(body_len + $urandom_range(2));
      end
      repeat ($urandom_range(3)) comp_bytes = {comp_bytes, 8'($urandom_range(255))};

      // first random case: receiver holds off long enough to back up the input
      if (phase_no == 0) rx_hold_left = HOLD_CYCLES;
      play_case(24'(total), in_total);
      fed_items += body_len;
      phase_no++;
    end

    while (dec.decoded_words.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (dec.errors == 0 && dec.decoded_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
